// File: rtl/rx_line_ring_buffer_top_assert.svh
// assertion macros used by the checker file
`ifndef RX_LINE_RING_BUFFER_TOP_ASSERT_SVH
`define RX_LINE_RING_BUFFER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define RLRB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlrb assertion failed");

// next-cycle implication
`define RLRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlrb assertion failed");

`endif

// File: rtl/rlrb_pkg.sv
package rlrb_pkg;

    localparam int RING_DEPTH = 64;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_ALL   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_LINE    = 2'd1;
    localparam logic [1:0] ST_EMPTY_LINE = 2'd2;
    localparam logic [1:0] ST_RING_EMPTY = 2'd3;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [6:0] RING_LEN_RESET = 7'd64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_lf;
    } t_cmd;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
        logic [1:0] status;
        logic [6:0] lines_left;
        logic [6:0] bytes_left;
        logic       overflow;
    } t_result;

endpackage

// File: rtl/rlrb_front.sv
module rlrb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_rx_byte,
    output rlrb_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);

    rlrb_pkg::t_cmd r_q [0:1];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           push;
    rlrb_pkg::t_cmd cmd_in;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // classify the item on the way in
    always_comb begin
        cmd_in.kind  = i_kind;
        cmd_in.data  = i_rx_byte;
        cmd_in.is_lf = (i_kind == rlrb_pkg::KIND_BYTE) && (i_rx_byte == rlrb_pkg::CH_LF);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/rlrb_back.sv
module rlrb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlrb_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  logic                i_cfg_valid,
    input  logic [6:0]          i_cfg_data,
    output rlrb_pkg::t_result   o_res,
    output logic                o_res_valid,
    input  logic                i_res_stall
);

    localparam int AW = (rlrb_pkg::RING_DEPTH > 1) ? $clog2(rlrb_pkg::RING_DEPTH) : 1;
    localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(rlrb_pkg::RING_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LINE = 2'd1;
    localparam logic [1:0] S_ALL  = 2'd2;

    logic [7:0]        r_mem [0:rlrb_pkg::RING_DEPTH-1];
    logic [7:0]        r_rdata;
    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [6:0]        r_bytes, n_bytes;
    logic [6:0]        r_lines, n_lines;
    logic              r_ovf, n_ovf;
    logic [6:0]        r_ring_len;
    logic              r_first, n_first;
    logic [1:0]        r_st, n_st;
    logic              r_out_valid;
    rlrb_pkg::t_result r_out, n_out;

    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     eff_len;
    logic [CW-1:0]     wr_inc;
    logic [CW-1:0]     rd_inc;
    logic [AW-1:0]     wr_adv;
    logic [AW-1:0]     rd_adv;
    logic              full;
    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic [7:0]        shown;
    logic              is_lf;
    logic              done;
    logic [6:0]        bytes_dec;

    assign len_ext = {{(CW-7){1'b0}}, r_ring_len};

    always_comb begin
        if (len_ext < CW'(2)) begin
            eff_len = CW'(2);
        end else if (len_ext > DEPTH_C) begin
            eff_len = DEPTH_C;
        end else begin
            eff_len = len_ext;
        end
    end

    // pointers wrap once they reach the ring length in use
    assign wr_inc = CW'(r_wr_ptr) + CW'(1);
    assign rd_inc = CW'(r_rd_ptr) + CW'(1);
    assign wr_adv = (wr_inc >= eff_len) ? '0 : wr_inc[AW-1:0];
    assign rd_adv = (rd_inc >= eff_len) ? '0 : rd_inc[AW-1:0];

    assign full      = ({{(CW-7){1'b0}}, r_bytes} >= eff_len);
    assign out_free  = !r_out_valid || !i_res_stall;
    assign is_lf     = (r_rdata == rlrb_pkg::CH_LF);
    assign shown     = (is_lf || r_rdata == rlrb_pkg::CH_CR) ? rlrb_pkg::CH_NUL : r_rdata;
    assign bytes_dec = r_bytes - 7'd1;

    always_comb begin
        n_state   = r_state;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_bytes   = r_bytes;
        n_lines   = r_lines;
        n_ovf     = r_ovf;
        n_first   = r_first;
        n_st      = r_st;
        n_out     = r_out;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        o_cmd_pop = 1'b0;
        done      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        rlrb_pkg::KIND_BYTE: begin
                            o_cmd_pop = 1'b1;
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                mem_we   = 1'b1;
                                n_wr_ptr = wr_adv;
                                n_bytes  = r_bytes + 7'd1;
                                if (i_cmd.is_lf) begin
                                    n_lines = r_lines + 7'd1;
                                end
                            end
                        end
                        rlrb_pkg::KIND_LINE: begin
                            if (r_lines == 7'd0) begin
                                if (out_free) begin
                                    o_cmd_pop = 1'b1;
                                    out_load  = 1'b1;
                                    n_out     = '{rlrb_pkg::CH_NUL, 1'b1,
                                                  rlrb_pkg::ST_NO_LINE,
                                                  r_lines, r_bytes, r_ovf};
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                n_first   = 1'b1;
                                n_state   = S_LINE;
                            end
                        end
                        rlrb_pkg::KIND_ALL: begin
                            if (r_bytes == 7'd0) begin
                                if (out_free) begin
                                    o_cmd_pop = 1'b1;
                                    out_load  = 1'b1;
                                    n_out     = '{rlrb_pkg::CH_NUL, 1'b1,
                                                  rlrb_pkg::ST_RING_EMPTY,
                                                  r_lines, r_bytes, r_ovf};
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                n_lines   = 7'd0;
                                n_state   = S_ALL;
                            end
                        end
                        rlrb_pkg::KIND_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_rd_ptr  = r_wr_ptr;
                            n_bytes   = 7'd0;
                            n_lines   = 7'd0;
                            n_ovf     = 1'b0;
                        end
                    endcase
                end
            end
            S_LINE: begin
                if (out_free) begin
                    // empty line is judged on the first byte of the run only
                    n_st     = r_first ? ((shown == rlrb_pkg::CH_NUL) ?
                                          rlrb_pkg::ST_EMPTY_LINE : rlrb_pkg::ST_OK) : r_st;
                    n_first  = 1'b0;
                    n_bytes  = bytes_dec;
                    n_lines  = is_lf ? (r_lines - 7'd1) : r_lines;
                    done     = is_lf || (bytes_dec == 7'd0);
                    if (done && !is_lf) begin
                        n_lines = 7'd0;
                    end
                    n_rd_ptr = rd_adv;
                    out_load = 1'b1;
                    n_out    = '{shown, done, n_st, n_lines, n_bytes, r_ovf};
                    if (done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ALL: begin
                if (out_free) begin
                    n_bytes  = bytes_dec;
                    done     = (bytes_dec == 7'd0);
                    n_rd_ptr = rd_adv;
                    out_load = 1'b1;
                    n_out    = '{r_rdata, done, rlrb_pkg::ST_OK, r_lines, bytes_dec, r_ovf};
                    if (done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read address follows the next read pointer so a run pops one byte a cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= i_cmd.data;
        end
        r_rdata <= r_mem[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
        r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_bytes     <= 7'd0;
            r_lines     <= 7'd0;
            r_ovf       <= 1'b0;
            r_first     <= 1'b0;
            r_ring_len  <= rlrb_pkg::RING_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_bytes  <= n_bytes;
            r_lines  <= n_lines;
            r_ovf    <= n_ovf;
            r_first  <= n_first;
            if (i_cfg_valid) begin
                r_ring_len <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

// File: rtl/rx_line_ring_buffer_top.sv
// path: a status result passes the command queue and the result register, the first byte
// of a read run passes the command queue, the registered ring read and the result register
// throughput: one transaction a cycle into the queue unless it is full; received bytes and
// clears run from idle; a read run pops one byte a cycle while the output is not stalled
// reset: synchronous, active low; counts, pointers and overflow clear, ring length back to 64
module rx_line_ring_buffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic       o_last,
    output logic [1:0] o_status,
    output logic [6:0] o_lines_left,
    output logic [6:0] o_bytes_left,
    output logic       o_overflow,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    rlrb_pkg::t_cmd    cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    rlrb_pkg::t_result res;

    rlrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    rlrb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res),
        .o_res_valid (o_out_valid),
        .i_res_stall (i_out_stall)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_char_out   = res.char_out;
    assign o_last       = res.last;
    assign o_status     = res.status;
    assign o_lines_left = res.lines_left;
    assign o_bytes_left = res.bytes_left;
    assign o_overflow   = res.overflow;

endmodule

// File: rtl/rlrb_checker.sv
`include "rx_line_ring_buffer_top_assert.svh"

module rlrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_char_out,
    input logic       o_last,
    input logic [1:0] o_status,
    input logic [6:0] o_lines_left,
    input logic [6:0] o_bytes_left
);

    // a stalled result holds
    `RLRB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_char_out) && $stable(o_last) && $stable(o_status) && $stable(o_bytes_left))

    // status-only results carry a nul and close the run
    `RLRB_ASSERT_NOW(a_status_shape, o_out_valid && (o_status == rlrb_pkg::ST_NO_LINE || o_status == rlrb_pkg::ST_RING_EMPTY), o_last && o_char_out == rlrb_pkg::CH_NUL)

    `RLRB_ASSERT_NOW(a_no_line_count, o_out_valid && o_status == rlrb_pkg::ST_NO_LINE, o_lines_left == 7'd0)

    `RLRB_ASSERT_NOW(a_ring_empty_count, o_out_valid && o_status == rlrb_pkg::ST_RING_EMPTY, o_bytes_left == 7'd0 && o_lines_left == 7'd0)

    // a read run has no bubbles once its output is taken
    `RLRB_ASSERT_NEXT(a_run_no_gap, o_out_valid && !i_out_stall && !o_last, o_out_valid)

endmodule

bind rx_line_ring_buffer_top rlrb_checker u_rlrb_checker (.*);

// File: tb/rx_line_ring_buffer_top_tb.sv
`timescale 1ns / 1ps

module rx_line_ring_buffer_top_tb;
    import rlrb_pkg::*;

    localparam int DEPTH         = RING_DEPTH;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;

    localparam t_result NO_LINE_RES = '{char_out: CH_NUL, last: 1'b1, status: ST_NO_LINE,
                                        lines_left: 7'd0, bytes_left: 7'd0, overflow: 1'b0};
    localparam t_result RING_EMPTY_RES = '{char_out: CH_NUL, last: 1'b1,
                                           status: ST_RING_EMPTY, lines_left: 7'd0,
                                           bytes_left: 7'd0, overflow: 1'b0};
    localparam t_result NO_RES = '0;

    typedef struct packed {
        bit         is_cfg;
        logic [6:0] cfg_val;
        logic [1:0] kind;
        logic [7:0] data;
        bit         typed;
        t_result    res;
    } stim_row_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_kind      = KIND_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [6:0] i_cfg_data  = RING_LEN_RESET;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic       o_last;
    logic [1:0] o_status;
    logic [6:0] o_lines_left;
    logic [6:0] o_bytes_left;
    logic       o_overflow;
    logic       o_cfg_ready;

    rx_line_ring_buffer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_out   (o_char_out),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_lines_left (o_lines_left),
        .o_bytes_left (o_bytes_left),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predicted ring state
    logic [7:0] ring_mem [DEPTH];
    int         wr_ptr       = 0;
    int         rd_ptr       = 0;
    int         n_bytes      = 0;
    int         n_lines      = 0;
    logic       ovf_flag     = 1'b0;
    logic [6:0] ring_len_reg = RING_LEN_RESET;

    t_result    pending_chars [$];
    t_result    got_res;
    t_result    want_res;

    int errors          = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int phase_items     = 0;
    int src_idle_pct    = 0;
    int stall_pct       = 0;
    int dropped_bytes   = 0;
    int cfg_writes      = 0;
    int kind_count [4]  = '{0, 0, 0, 0};

    logic [6:0] phase_lens [0:7] = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd5, 7'd0, 7'd17, 7'd64};

    stim_row_t dir_rows [0:26] = '{
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b1, NO_LINE_RES},
        '{1'b0, 7'd0,   KIND_ALL,   8'hFF,  1'b1, RING_EMPTY_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  8'hFF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_NUL, 1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_CR,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_LF,  1'b0, NO_RES},
        // shrink with a line stored: the read wraps before the newline and runs dry
        '{1'b1, 7'd3,   KIND_BYTE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b0, NO_RES},
        '{1'b1, 7'd127, KIND_BYTE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_CLEAR, 8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_LF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_CR,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  8'h41,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_LF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_LF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  8'h55,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_ALL,   8'h00,  1'b0, NO_RES},
        '{1'b1, 7'd0,   KIND_BYTE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  8'hAA,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  CH_LF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_BYTE,  8'h33,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_CLEAR, 8'hFF,  1'b0, NO_RES},
        '{1'b0, 7'd0,   KIND_LINE,  8'h00,  1'b1, NO_LINE_RES},
        '{1'b1, 7'd64,  KIND_BYTE,  8'h00,  1'b0, NO_RES}
    };

    function automatic int ring_span();
        if (ring_len_reg < 7'd2) return 2;
        if (ring_len_reg > DEPTH) return DEPTH;
        return int'(ring_len_reg);
    endfunction

    function automatic int next_slot(input int p);
        return (p + 1 >= ring_span()) ? 0 : p + 1;
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic last,
                                        input logic [1:0] st);
        t_result r;
        r.char_out   = ch;
        r.last       = last;
        r.status     = st;
        r.lines_left = 7'(n_lines);
        r.bytes_left = 7'(n_bytes);
        r.overflow   = ovf_flag;
        pending_chars.push_back(r);
    endfunction

    function automatic logic [7:0] pop_char();
        logic [7:0] c;
        c       = ring_mem[rd_ptr % DEPTH];
        rd_ptr  = next_slot(rd_ptr % DEPTH);
        n_bytes = n_bytes - 1;
        return c;
    endfunction

    task automatic predict_popped_chars(input logic [1:0] kind, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] shown;
        logic [1:0] st;
        bit         first;
        bit         done;
        case (kind)
            KIND_BYTE: begin
                if (n_bytes >= ring_span()) begin
                    ovf_flag      = 1'b1;
                    dropped_bytes = dropped_bytes + 1;
                end else begin
                    ring_mem[wr_ptr % DEPTH] = data;
                    wr_ptr  = next_slot(wr_ptr % DEPTH);
                    n_bytes = n_bytes + 1;
                    if (data == CH_LF) n_lines = n_lines + 1;
                end
            end
            KIND_LINE: begin
                if (n_lines == 0) begin
                    push_result(CH_NUL, 1'b1, ST_NO_LINE);
                end else begin
                    st    = ST_OK;
                    first = 1'b1;
                    done  = 1'b0;
                    while (n_bytes > 0 && !done) begin
                        c     = pop_char();
                        shown = (c == CH_CR || c == CH_LF) ? CH_NUL : c;
                        if (first && shown == CH_NUL) st = ST_EMPTY_LINE;
                        first = 1'b0;
                        if (c == CH_LF) n_lines = n_lines - 1;
                        done = (c == CH_LF) || (n_bytes == 0);
                        // ran dry before a newline
                        if (done && c != CH_LF) n_lines = 0;
                        push_result(shown, done, st);
                    end
                end
            end
            KIND_ALL: begin
                if (n_bytes == 0) begin
                    push_result(CH_NUL, 1'b1, ST_RING_EMPTY);
                end else begin
                    n_lines = 0;
                    while (n_bytes > 0) begin
                        c = pop_char();
                        push_result(c, n_bytes == 0, ST_OK);
                    end
                end
            end
            default: begin
                rd_ptr   = wr_ptr;
                n_bytes  = 0;
                n_lines  = 0;
                ovf_flag = 1'b0;
            end
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_cmd(input logic [1:0] kind, input logic [7:0] data,
                            input bit typed = 1'b0, input t_result typed_res = '0);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_kind     = kind;
        i_rx_byte  = data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_popped_chars(kind, data);
        // status rows typed into the table stand in for the single predicted result
        if (typed) begin
            pending_chars.delete(pending_chars.size() - 1);
            pending_chars.push_back(typed_res);
        end
        kind_count[kind] = kind_count[kind] + 1;
        phase_items      = phase_items + 1;
        @(negedge i_clk);
    endtask

    task automatic write_ring_length(input logic [6:0] len);
        i_in_valid = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        // clears and stored bytes give no result, so let the pipeline settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ring_len_reg = len;
        cfg_writes   = cfg_writes + 1;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5) return 8'($urandom_range(8'h20, 8'h7E));
        if (r == 6) return CH_CR;
        if (r == 7) return CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            // well-formed line, mostly read back straight away
            n = $urandom_range(0, 8);
            repeat (n) send_cmd(KIND_BYTE, pick_byte());
            send_cmd(KIND_BYTE, CH_LF);
            if ($urandom_range(0, 9) < 7) send_cmd(KIND_LINE, 8'($urandom_range(0, 255)));
        end else if (pick == 6) begin
            send_cmd(KIND_LINE, 8'($urandom_range(0, 255)));
        end else if (pick == 7) begin
            send_cmd(KIND_ALL, 8'($urandom_range(0, 255)));
        end else if (pick == 8 && $urandom_range(0, 1) == 1) begin
            send_cmd(KIND_CLEAR, 8'($urandom_range(0, 255)));
        end else begin
            send_cmd(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_res = '{o_char_out, o_last, o_status, o_lines_left, o_bytes_left, o_overflow};
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0h", $time, got_res);
                errors = errors + 1;
            end else begin
                want_res = pending_chars.pop_front();
                check_field("char_out", want_res.char_out, got_res.char_out);
                check_field("last", want_res.last, got_res.last);
                check_field("status", want_res.status, got_res.status);
                check_field("lines_left", want_res.lines_left, got_res.lines_left);
                check_field("bytes_left", want_res.bytes_left, got_res.bytes_left);
                check_field("overflow", want_res.overflow, got_res.overflow);
                results_checked = results_checked + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_chars.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int ph;
        foreach (ring_mem[i]) ring_mem[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_ring_length(dir_rows[i].cfg_val);
            else
                send_cmd(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed,
                         dir_rows[i].res);
        end

        for (ph = 0; ph < 8; ph++) begin
            src_idle_pct = 0;
            stall_pct    = 0;
            // length only changes with the ring empty, so no unwritten slot is read
            if (n_bytes != 0) send_cmd(KIND_CLEAR, 8'($urandom_range(0, 255)));
            write_ring_length(phase_lens[ph]);
            case (ph % 4)
                1: src_idle_pct = 67;
                2: stall_pct = 67;
                3: begin
                    src_idle_pct = 35;
                    stall_pct    = 35;
                end
                default: ;
            endcase
            phase_items = 0;
            // fill past full to reach the overflow path
            if (phase_lens[ph] > DEPTH || ring_span() <= 5)
                repeat (ring_span() + $urandom_range(1, 2)) send_cmd(KIND_BYTE, pick_byte());
            while (phase_items < 8) send_random_sequence();
        end

        i_in_valid = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d byte, %0d line read, %0d drain and %0d clear transactions",
                 kind_count[KIND_BYTE], kind_count[KIND_LINE], kind_count[KIND_ALL],
                 kind_count[KIND_CLEAR]);
        $display("%0d results checked, %0d bytes dropped on full, %0d ring length writes",
                 results_checked, dropped_bytes, cfg_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
